FILE: rtl/core/srp_pkg.sv
// Shared types and constants for the status report parser.
// Holds the beat payload structs, parse phase and status codes, and the
// parser state record passed between the decoder and the top level.
package srp_pkg;

   localparam int unsigned MAX_NACKS = 32;
   localparam int unsigned BUF_W     = 64;
   localparam int unsigned HELD_W    = 6;
   localparam int unsigned SN_W      = 10;
   localparam int unsigned SO_W      = 15;
   localparam int unsigned CNT_W     = 6;
   localparam int unsigned BYTES_W   = 8;

   localparam logic [HELD_W-1:0]  HDR_FIRST_BITS = HELD_W'(8);
   localparam logic [HELD_W-1:0]  HDR_BITS       = HELD_W'(15);
   localparam logic [HELD_W-1:0]  NACK_BITS      = HELD_W'(12);
   localparam logic [HELD_W-1:0]  NACK_SO_BITS   = HELD_W'(42);
   localparam logic [HELD_W-1:0]  BYTE_BITS      = HELD_W'(8);
   localparam logic [SO_W-1:0]    SO_END_ABSENT  = 15'h7FFF;
   localparam logic [BYTES_W-1:0] BYTES_MAX      = 8'hFF;

   localparam logic REC_HEADER = 1'b0;
   localparam logic REC_NACK   = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_NACKS  = 2'd2,
      PHASE_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DATA_PDU = 2'd1,
      STATUS_BAD_CPT  = 2'd2,
      STATUS_TOO_MANY = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       pdu_start;
   } req_type;

   typedef struct packed {
      logic               rec_kind;
      logic [SN_W-1:0]    ack_sn;
      logic [SN_W-1:0]    nack_sn;
      logic               has_offsets;
      logic [SO_W-1:0]    so_begin;
      logic [SO_W-1:0]    so_end;
      status_type         status;
      logic [CNT_W-1:0]   nack_pos;
      logic [BYTES_W-1:0] pdu_bytes;
      logic               last;
   } rsp_type;

   typedef struct packed {
      phase_type          phase;
      logic [BUF_W-1:0]   bit_buf;
      logic [HELD_W-1:0]  held;
      logic [SN_W-1:0]    ack_sn;
      logic [CNT_W-1:0]   nack_count;
      logic [BYTES_W-1:0] byte_count;
   } state_type;

   // Mask of the n low bits; n never reaches the buffer width.
   function automatic logic [BUF_W-1:0] low_mask(input logic [HELD_W-1:0] n);
      return ~({BUF_W{1'b1}} << n);
   endfunction

endpackage

FILE: rtl/core/srp_decode.sv
// Combinational decode of one byte of a status PDU against the parser state.
// Depends on srp_pkg for the payload, state and code types.
module srp_decode (
   input  srp_pkg::state_type cur_state,
   input  srp_pkg::req_type   req,
   output srp_pkg::state_type nxt_state,
   output logic               emit,
   output srp_pkg::rsp_type   rec
);
   import srp_pkg::*;

   state_type           base;
   logic [BUF_W-1:0]    buf_a;
   logic [HELD_W-1:0]   held_a;
   logic [BYTES_W-1:0]  bytes_a;
   logic [BUF_W-1:0]    peek12;
   logic [BUF_W-1:0]    peek42;
   logic [HELD_W-1:0]   held_d;
   logic [CNT_W-1:0]    cnt_n;
   logic                e1;
   logic                e2;

   always_comb begin
      base = cur_state;
      if (req.pdu_start) begin
         base.phase      = PHASE_HEADER;
         base.bit_buf    = '0;
         base.held       = '0;
         base.ack_sn     = '0;
         base.nack_count = '0;
         base.byte_count = '0;
      end

      buf_a   = {base.bit_buf[BUF_W-9:0], req.data_byte};
      held_a  = base.held + BYTE_BITS;
      bytes_a = (base.byte_count == BYTES_MAX) ? base.byte_count
                                               : base.byte_count + BYTES_W'(1);
      peek12  = buf_a >> (held_a - NACK_BITS);
      peek42  = buf_a >> (held_a - NACK_SO_BITS);
      held_d  = '0;
      cnt_n   = base.nack_count + CNT_W'(1);
      e1      = 1'b0;
      e2      = 1'b0;

      nxt_state = base;
      emit      = 1'b0;
      rec       = '0;
      rec.pdu_bytes = bytes_a;

      if (base.phase == PHASE_HEADER || base.phase == PHASE_NACKS) begin
         nxt_state.bit_buf    = buf_a;
         nxt_state.held       = held_a;
         nxt_state.byte_count = bytes_a;
      end

      case (base.phase)
         PHASE_HEADER: begin
            if (held_a == HDR_FIRST_BITS) begin
               if (req.data_byte[7]) begin
                  nxt_state.phase = PHASE_DONE;
                  emit            = 1'b1;
                  rec.status      = STATUS_DATA_PDU;
                  rec.last        = 1'b1;
               end else if (req.data_byte[6:4] != 3'd0) begin
                  nxt_state.phase = PHASE_DONE;
                  emit            = 1'b1;
                  rec.status      = STATUS_BAD_CPT;
                  rec.last        = 1'b1;
               end
            end else begin
               // Second byte: the header is always the top 15 of the 16 held bits here.
               e1               = buf_a[1];
               held_d           = held_a - HDR_BITS;
               nxt_state.ack_sn = buf_a[11:2];
               nxt_state.held   = held_d;
               nxt_state.bit_buf = buf_a & low_mask(held_d);
               nxt_state.phase  = e1 ? PHASE_NACKS : PHASE_DONE;
               emit             = 1'b1;
               rec.rec_kind     = REC_HEADER;
               rec.ack_sn       = buf_a[11:2];
               rec.status       = STATUS_OK;
               rec.last         = ~e1;
            end
         end
         PHASE_NACKS: begin
            e1 = peek12[1];
            e2 = peek12[0];
            if (held_a >= NACK_BITS && (!e2 || held_a >= NACK_SO_BITS)) begin
               held_d = e2 ? held_a - NACK_SO_BITS : held_a - NACK_BITS;
               nxt_state.held       = held_d;
               nxt_state.bit_buf    = buf_a & low_mask(held_d);
               nxt_state.nack_count = cnt_n;
               emit             = 1'b1;
               rec.rec_kind     = REC_NACK;
               rec.ack_sn       = base.ack_sn;
               rec.nack_sn      = peek12[11:2];
               rec.has_offsets  = e2;
               rec.so_begin     = e2 ? peek42[29:15] : '0;
               rec.so_end       = e2 ? peek42[14:0] : SO_END_ABSENT;
               rec.nack_pos     = base.nack_count;
               rec.status       = STATUS_OK;
               if (!e1) begin
                  rec.last        = 1'b1;
                  nxt_state.phase = PHASE_DONE;
               end else if (cnt_n >= CNT_W'(MAX_NACKS) || cnt_n == '0) begin
                  rec.status      = STATUS_TOO_MANY;
                  rec.last        = 1'b1;
                  nxt_state.phase = PHASE_DONE;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/status_report_parser.sv
// Status report parser: one PDU byte per beat, at most one record per beat.
// Flow: a byte is registered on entry and its record, if any, is decoded into
// the output register once that register can take it (rsp_stall can hold it).
// Throughput: one byte per cycle while the output is not stalled; the parser
// state closes its loop in the single decode stage. Reset is synchronous: the
// parse returns to idle with an empty bit buffer and both pipeline registers empty.
module status_report_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srp_pkg::rsp_type rsp_data
);
   import srp_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff, in_data_in;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   state_type dec_state;
   logic      dec_emit;
   rsp_type   dec_rec;
   logic      advance;
   logic      req_take;

   srp_decode u_decode (
      .cur_state (state_ff),
      .req       (in_data_ff),
      .nxt_state (dec_state),
      .emit      (dec_emit),
      .rec       (dec_rec)
   );

   // The held byte is decoded once the output register can take a result.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         state_in     = dec_state;
         rsp_valid_in = dec_emit;
         if (dec_emit) begin
            rsp_data_in = dec_rec;
         end
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase      <= PHASE_IDLE;
         state_ff.bit_buf    <= '0;
         state_ff.held       <= '0;
         state_ff.ack_sn     <= '0;
         state_ff.nack_count <= '0;
         state_ff.byte_count <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
